// ----- hw/rtl/gbns_pkg.sv -----
// gbns_pkg: shared types, codes and sizes of the go-back-n sender window
// used by gbns_core and go_back_n_sender_window; no dependencies
package gbns_pkg;

    localparam int IDX_W      = 16;   // packet index width
    localparam int SEQ_W      = 8;    // sequence number width
    localparam int WIN_W      = 8;    // window size width, holds MAX_WINDOW
    localparam int ATT_W      = 4;    // attempt counter width
    localparam int MAX_WINDOW = 128;

    localparam logic [WIN_W-1:0] MAX_WIN          = WIN_W'(MAX_WINDOW);
    localparam logic [ATT_W-1:0] MAX_ATTEMPTS_RST = ATT_W'(5);

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_ACK   = 2'd1,
        REQ_TIMER = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        STS_BUSY = 2'd0,
        STS_DONE = 2'd1,
        STS_FAIL = 2'd2,
        STS_IDLE = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type        req_type;
        logic [IDX_W-1:0] pkt_total;
        logic [SEQ_W-1:0] ack_seq;
        logic             ack_good;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0] send_first_index;
        logic [SEQ_W-1:0] send_first_seq;
        logic [WIN_W-1:0] send_count;
        logic             timer_restart;
        t_status          status;
    } t_result;

    typedef struct packed {
        logic             active;
        logic [IDX_W-1:0] message_length;
        logic [IDX_W-1:0] head_index;
        logic [IDX_W-1:0] next_index;
        logic [SEQ_W-1:0] head_seq;
        logic [WIN_W-1:0] win_size;
        logic [ATT_W-1:0] attempt_count;
    } t_state;

    localparam t_state STATE_RST = '{
        active:         1'b0,
        message_length: '0,
        head_index:     '0,
        next_index:     '0,
        head_seq:       '0,
        win_size:       WIN_W'(1),
        attempt_count:  '0
    };

endpackage

// ----- hw/rtl/go_back_n_sender_window.sv -----
// go_back_n_sender_window: top level of the go-back-n sender window control
// depends on gbns_pkg and gbns_core
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: count, seq, good; tuser: kind
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: index, seq, count, restart; tuser: status
//  cfg       in   i_cfg_we                     i_cfg_wdata: max attempts
//
// one item per cycle sustained while m_axis takes results; an item passes the input register, then the result register
// the whole event is decided in one pass through gbns_core against the state registers
// synchronous active-low reset clears both valid flags, the window state and max attempts (5)
// a stall on m_axis holds the result and the pending input item; s_axis_tready drops
// only when both stages are full and the result is not taken
module go_back_n_sender_window
    import gbns_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] pkt_total, [23:16] ack_seq, [24] ack_good, [31:25] zero
    input  logic [31:0]       s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]        s_axis_tuser,

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [15:0] send_first_index, [23:16] send_first_seq, [31:24] send_count,
    // [32] timer_restart, [39:33] zero
    output logic [39:0]       m_axis_tdata,
    // [1:0] status
    output logic [1:0]        m_axis_tuser,

    input  logic              i_cfg_we,
    input  logic [ATT_W-1:0]  i_cfg_wdata
);

    // input stage
    logic             r_in_valid;
    t_item            r_in;
    // result stage
    logic             r_out_valid;
    t_result          r_out;
    // sender state and configuration
    t_state           r_state;
    logic [ATT_W-1:0] r_max_attempts;

    t_state           n_state;
    t_result          n_result;
    t_item            in_item;
    logic             advance;
    logic             in_fire;

    // unpack the incoming item
    assign in_item.req_type  = t_req_type'(s_axis_tuser);
    assign in_item.pkt_total = s_axis_tdata[15:0];
    assign in_item.ack_seq   = s_axis_tdata[23:16];
    assign in_item.ack_good  = s_axis_tdata[24];

    // the held item moves into the result register when that is free or being drained
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    gbns_core u_core (
        .i_item         (r_in),
        .i_state        (r_state),
        .i_max_attempts (r_max_attempts),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_state        <= STATE_RST;
            r_max_attempts <= MAX_ATTEMPTS_RST;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_max_attempts <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= in_item;
        end
        if (advance) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.timer_restart, r_out.send_count,
                            r_out.send_first_seq, r_out.send_first_index};
    assign m_axis_tuser  = r_out.status;

    // window never collapses to zero nor exceeds its maximum
    a_window_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.win_size != '0) && (r_state.win_size <= MAX_WIN))
        else $error("window size out of range");

    // while a transfer runs, head sits below the length and never passes next
    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.active |-> (r_state.head_index < r_state.message_length)
                           && (r_state.head_index <= r_state.next_index)
                           && (r_state.next_index <= r_state.message_length))
        else $error("window indices out of order");

    // a failure or completion sends nothing and leaves the timer stopped
    a_final_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == STS_FAIL || r_out.status == STS_DONE))
        |-> (r_out.send_count == '0) && !r_out.timer_restart)
        else $error("final result carries a send");

    // failure or completion leaves the sender idle
    a_idle_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (n_result.status == STS_FAIL || n_result.status == STS_DONE))
        |=> !r_state.active)
        else $error("sender still active after final result");

    // a single result never sends more than the maximum window
    a_send_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.send_count <= MAX_WIN))
        else $error("send count exceeds window");

endmodule

// ----- hw/rtl/gbns_core.sv -----
// gbns_core: next state and result for one sender event, pure logic
// depends on gbns_pkg
module gbns_core
    import gbns_pkg::*;
(
    input  t_item            i_item,
    input  t_state           i_state,
    input  logic [ATT_W-1:0] i_max_attempts,
    output t_state           o_state,
    output t_result          o_result
);

    logic [SEQ_W-1:0] ack_off;
    logic [IDX_W-1:0] outstanding;
    logic             ack_ok;
    logic [IDX_W-1:0] head_adv;
    logic [SEQ_W-1:0] seq_adv;
    logic [WIN_W:0]   win_dbl;
    logic [WIN_W-1:0] win_up;
    logic [WIN_W-1:0] win_half;
    logic [WIN_W-1:0] win_dn;
    logic [ATT_W-1:0] att_inc;
    logic [IDX_W:0]   ack_limit;
    logic             send_more;
    logic [SEQ_W-1:0] more_seq;
    logic [IDX_W-1:0] sw_head;
    logic [IDX_W-1:0] sw_left;
    logic [WIN_W-1:0] sw_win;
    logic [WIN_W-1:0] sw_cnt;

    // acknowledgement window check
    assign ack_off     = i_item.ack_seq - i_state.head_seq;
    assign outstanding = i_state.next_index - i_state.head_index;
    assign ack_ok      = i_state.active && i_item.ack_good
                         && (ack_off < i_state.win_size)
                         && (IDX_W'(ack_off) < outstanding);
    assign head_adv    = i_state.head_index + IDX_W'(ack_off) + IDX_W'(1);
    assign seq_adv     = i_state.head_seq + ack_off + SEQ_W'(1);

    // window grows by doubling, shrinks by halving
    assign win_dbl  = {i_state.win_size, 1'b0};
    assign win_up   = (win_dbl > (WIN_W+1)'(MAX_WINDOW)) ? MAX_WIN : win_dbl[WIN_W-1:0];
    assign win_half = i_state.win_size >> 1;
    assign win_dn   = (win_half == '0) ? WIN_W'(1) : win_half;
    assign att_inc  = i_state.attempt_count + ATT_W'(1);

    // one more packet after an accepted ack
    assign ack_limit = {1'b0, head_adv} + (IDX_W+1)'(win_up);
    assign send_more = (i_state.next_index < i_state.message_length)
                       && ({1'b0, i_state.next_index} < ack_limit);
    assign more_seq  = seq_adv + i_state.next_index[SEQ_W-1:0] - head_adv[SEQ_W-1:0];

    // full window from the head, on start or on timeout
    assign sw_head = (i_item.req_type == REQ_START) ? '0 : i_state.head_index;
    assign sw_left = (i_item.req_type == REQ_START) ? i_item.pkt_total
                                                    : i_state.message_length - i_state.head_index;
    assign sw_win  = (i_item.req_type == REQ_START) ? i_state.win_size : win_dn;
    assign sw_cnt  = (IDX_W'(sw_win) < sw_left) ? sw_win : sw_left[WIN_W-1:0];

    always_comb begin
        o_state  = i_state;
        o_result = '{send_first_index: '0, send_first_seq: '0, send_count: '0,
                     timer_restart: 1'b0, status: STS_IDLE};
        unique case (i_item.req_type)
            REQ_START: begin
                o_state.message_length = i_item.pkt_total;
                o_state.head_index     = '0;
                o_state.next_index     = '0;
                o_state.attempt_count  = '0;
                if (i_item.pkt_total == '0) begin
                    o_state.active  = 1'b0;
                    o_result.status = STS_DONE;
                end else begin
                    o_state.active           = 1'b1;
                    o_state.next_index       = IDX_W'(sw_cnt);
                    o_result.send_first_index = sw_head;
                    o_result.send_first_seq   = i_state.head_seq;
                    o_result.send_count       = sw_cnt;
                    o_result.timer_restart    = 1'b1;
                    o_result.status           = STS_BUSY;
                end
            end
            REQ_ACK: begin
                if (ack_ok) begin
                    o_state.head_index    = head_adv;
                    o_state.head_seq      = seq_adv;
                    o_state.win_size      = win_up;
                    o_state.attempt_count = '0;
                    if (head_adv >= i_state.message_length) begin
                        o_state.active  = 1'b0;
                        o_result.status = STS_DONE;
                    end else begin
                        o_result.timer_restart = 1'b1;
                        o_result.status        = STS_BUSY;
                        if (send_more) begin
                            o_result.send_first_index = i_state.next_index;
                            o_result.send_first_seq   = more_seq;
                            o_result.send_count       = WIN_W'(1);
                            o_state.next_index        = i_state.next_index + IDX_W'(1);
                        end
                    end
                end
            end
            REQ_TIMER: begin
                if (i_state.active) begin
                    o_state.attempt_count = att_inc;
                    o_state.win_size      = win_dn;
                    if (att_inc >= i_max_attempts) begin
                        o_state.active  = 1'b0;
                        o_result.status = STS_FAIL;
                    end else begin
                        o_state.next_index        = i_state.head_index + IDX_W'(sw_cnt);
                        o_result.send_first_index = sw_head;
                        o_result.send_first_seq   = i_state.head_seq;
                        o_result.send_count       = sw_cnt;
                        o_result.timer_restart    = 1'b1;
                        o_result.status           = STS_BUSY;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule
